// ----- src/tcp_send_byte_buffer_top_assert.svh -----
// Assertion macros for the TCP send byte buffer checker.
// Used by tsbb_checker.sv only; no other dependencies.
`ifndef TCP_SEND_BYTE_BUFFER_TOP_ASSERT_SVH
`define TCP_SEND_BYTE_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSBB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcp_send_byte_buffer: assertion failed");

// Next-cycle implication, disabled during reset.
`define TSBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcp_send_byte_buffer: assertion failed");

`endif

// ----- src/tsbb_pkg.sv -----
// Shared types, codes and constants of the TCP send byte buffer.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package tsbb_pkg;

   localparam int RING_BYTES_DEFAULT = 65536;
   localparam int MAX_FETCH_DEFAULT  = 64;

   localparam int SEQ_W       = 32;
   localparam int CNT_W       = 17;
   localparam int LEN_W       = 7;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CNT_W-1:0] MAX_BUFFER_RESET = 17'd32768;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FETCH  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ACK    = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_STALE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_GAP   = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BUFFER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SEQ  = 1'b1;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [BYTE_W-1:0] data_byte;
      logic [SEQ_W-1:0]  seq_number;
      logic [LEN_W-1:0]  fetch_length;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                last_of_run;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    free_space;
      logic [SEQ_W-1:0]    head_seq_out;
      logic [CNT_W-1:0]    unsent_count;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic load_step;
      logic load_byte;
      logic rd_issue;
      logic last;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             fetch_run;
      logic [LEN_W-1:0] run_len;
   } dp_status_type;

endpackage

// ----- src/tsbb_if.sv -----
// Valid/ready stream interfaces for requests and responses.
// Depends on tsbb_pkg for the payload types.
`timescale 1ns / 1ps

interface tsbb_req_if;
   import tsbb_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tsbb_rsp_if;
   import tsbb_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/tcp_send_byte_buffer_top.sv -----
// TCP send byte buffer: a transmit byte ring addressed by 32-bit sequence numbers.
// An append request stores one byte at the tail, or is refused with status full
// once the held count reaches max_buffer or the ring size. A fetch request returns
// up to fetch_length bytes (capped at MAX_FETCH) from seq_number, one response
// per byte with last_of_run on the final one; already sent bytes are simply
// re-read, new ones move the sent mark. Stale, empty or gapped fetches give one
// empty response with a status. An acknowledge frees sent bytes up to seq_number.
// Every response also reports free space, head sequence and unsent count after
// the request. Appends, acknowledges and refused fetches can follow back to back
// while responses are taken. A fetch blocks new requests until its last byte
// enters the response register; the ring has a single registered read port, so
// each byte passes the read register first and the bytes follow one per cycle
// while responses are taken. The ring is never cleared; only written bytes are read.
// Depends on tsbb_pkg, tsbb_if, tsbb_datapath and tsbb_controller.
`timescale 1ns / 1ps

module tcp_send_byte_buffer_top #(
   parameter int RING_BYTES = tsbb_pkg::RING_BYTES_DEFAULT,
   parameter int MAX_FETCH  = tsbb_pkg::MAX_FETCH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   tsbb_req_if.sink                         req_if,
   tsbb_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [tsbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsbb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsbb_pkg::*;

   dp_cmd_type      cmd;
   dp_status_type   stat;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   // Sequencer: owns the handshake and walks a fetch one byte at a time
   tsbb_controller #(
      .MAX_FETCH (MAX_FETCH)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Buffer state, ring memory and the response register
   tsbb_datapath #(
      .RING_BYTES (RING_BYTES),
      .MAX_FETCH  (MAX_FETCH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   // Drive the channel ports
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;

endmodule

// ----- src/tsbb_datapath.sv -----
// Datapath: buffer state, byte ring memory, register file and response register.
// Depends on tsbb_pkg; driven by tsbb_controller through dp_cmd_type.
`timescale 1ns / 1ps

module tsbb_datapath #(
   parameter int RING_BYTES = tsbb_pkg::RING_BYTES_DEFAULT,
   parameter int MAX_FETCH  = tsbb_pkg::MAX_FETCH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tsbb_pkg::req_payload_type             req_payload,
   input  logic                                  csr_we,
   input  logic [tsbb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tsbb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  tsbb_pkg::dp_cmd_type                  cmd,
   output tsbb_pkg::dp_status_type               stat,
   output tsbb_pkg::rsp_payload_type             rsp_payload
);
   import tsbb_pkg::*;

   localparam int IDX_W = $clog2(RING_BYTES);
   localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
   localparam logic [SUM_W-1:0] RING_SUM  = SUM_W'(RING_BYTES);
   localparam logic [LEN_W-1:0] FETCH_CAP = LEN_W'(MAX_FETCH);

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] t;
      t = (sum >= RING_SUM) ? (sum - RING_SUM) : sum;
      return t[IDX_W-1:0];
   endfunction

   logic [BYTE_W-1:0] ring_mem [RING_BYTES];

   logic [SEQ_W-1:0] head_seq_ff, head_seq_in;
   logic [IDX_W-1:0] head_index_ff, head_index_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] sent_ff, sent_in;
   logic [CNT_W-1:0] max_buffer_ff, max_buffer_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BYTE_W-1:0] ram_q_ff;
   rsp_payload_type  rsp_ff, rsp_in;

   logic [SEQ_W-1:0]    offset;
   logic                stale, gap, app_ok, ack_do, run;
   logic [LEN_W-1:0]    len_c, run_s;
   logic [CNT_W-1:0]    avail, run_end, drop, off_lo;
   logic [IDX_W-1:0]    wr_addr, rd_start;
   logic [STATUS_W-1:0] step_status;
   logic [CNT_W-1:0]    free_rep, unsent_rep;

   always_comb begin
      offset = req_payload.seq_number - head_seq_ff;
      off_lo = offset[CNT_W-1:0];
      stale  = offset[SEQ_W-1];
      len_c  = (req_payload.fetch_length > FETCH_CAP) ? FETCH_CAP : req_payload.fetch_length;
      avail  = (offset <= SEQ_W'(held_ff)) ? (held_ff - off_lo) : '0;
      run_s  = (CNT_W'(len_c) < avail) ? len_c : avail[LEN_W-1:0];
      gap    = offset > SEQ_W'(sent_ff);
      run    = (req_payload.req_type == REQ_FETCH) && !stale && (run_s != '0) && !gap;
      run_end = off_lo + CNT_W'(run_s);
      app_ok  = (held_ff < max_buffer_ff) && (SUM_W'(held_ff) < RING_SUM);
      wr_addr  = ring_wrap(SUM_W'(head_index_ff) + SUM_W'(held_ff));
      rd_start = ring_wrap(SUM_W'(head_index_ff) + SUM_W'(off_lo));
      ack_do  = (offset != '0) && !stale;
      drop    = (offset < SEQ_W'(sent_ff)) ? off_lo : sent_ff;
   end

   assign stat.fetch_run = run;
   assign stat.run_len   = run_s;

   // Next state: request commit or CSR write; idle-only writes, user-enforced
   always_comb begin
      head_seq_in   = head_seq_ff;
      head_index_in = head_index_ff;
      held_in       = held_ff;
      sent_in       = sent_ff;
      max_buffer_in = max_buffer_ff;
      if (cmd.accept) begin
         case (req_payload.req_type)
            REQ_APPEND: begin
               if (app_ok) held_in = held_ff + 1'b1;
            end
            REQ_FETCH: begin
               if (run && (run_end > sent_ff)) sent_in = run_end;
            end
            REQ_ACK: begin
               if (ack_do) begin
                  held_in       = held_ff - drop;
                  sent_in       = sent_ff - drop;
                  head_seq_in   = head_seq_ff + SEQ_W'(drop);
                  head_index_in = ring_wrap(SUM_W'(head_index_ff) + SUM_W'(drop));
                  if (held_in == '0) head_seq_in = req_payload.seq_number;
               end
            end
            default: ;
         endcase
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_BUFFER: max_buffer_in = csr_wdata[CNT_W-1:0];
            CSR_START_SEQ:  head_seq_in   = csr_wdata[SEQ_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (req_payload.req_type)
         REQ_APPEND: step_status = app_ok ? STATUS_OK : STATUS_FULL;
         REQ_FETCH: begin
            if (stale)              step_status = STATUS_STALE;
            else if (run_s == '0)   step_status = STATUS_EMPTY;
            else if (gap)           step_status = STATUS_GAP;
            else                    step_status = STATUS_OK;
         end
         REQ_ACK:   step_status = STATUS_OK;
         default:   step_status = STATUS_EMPTY;
      endcase
      free_rep   = (max_buffer_in > held_in) ? (max_buffer_in - held_in) : '0;
      unsent_rep = (held_in >= sent_in) ? (held_in - sent_in) : '0;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_step || cmd.load_byte) begin
         rsp_in.out_byte     = cmd.load_byte ? ram_q_ff : '0;
         rsp_in.byte_valid   = cmd.load_byte;
         rsp_in.last_of_run  = cmd.load_step || cmd.last;
         rsp_in.status       = cmd.load_byte ? STATUS_OK : step_status;
         rsp_in.free_space   = free_rep;
         rsp_in.head_seq_out = head_seq_in;
         rsp_in.unsent_count = unsent_rep;
      end
      rd_ptr_in = rd_ptr_ff;
      if (cmd.accept) begin
         rd_ptr_in = rd_start;
      end else if (cmd.rd_issue) begin
         rd_ptr_in = ring_wrap(SUM_W'(rd_ptr_ff) + SUM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_seq_ff   <= '0;
         head_index_ff <= '0;
         held_ff       <= '0;
         sent_ff       <= '0;
         max_buffer_ff <= MAX_BUFFER_RESET;
      end else begin
         head_seq_ff   <= head_seq_in;
         head_index_ff <= head_index_in;
         held_ff       <= held_in;
         sent_ff       <= sent_in;
         max_buffer_ff <= max_buffer_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      rd_ptr_ff <= rd_ptr_in;
   end

   // Byte ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_payload.req_type == REQ_APPEND) && app_ok) begin
         ring_mem[wr_addr] <= req_payload.data_byte;
      end
      if (cmd.rd_issue) begin
         ram_q_ff <= ring_mem[rd_ptr_ff];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- src/tsbb_controller.sv -----
// Controller: request handshake, fetch sequencing and response valid.
// Depends on tsbb_pkg; steers tsbb_datapath through dp_cmd_type.
`timescale 1ns / 1ps

module tsbb_controller #(
   parameter int MAX_FETCH = tsbb_pkg::MAX_FETCH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tsbb_pkg::dp_status_type stat,
   output tsbb_pkg::dp_cmd_type    cmd
);
   import tsbb_pkg::*;

   localparam int FW = $clog2(MAX_FETCH + 1);

   typedef enum logic {ST_IDLE, ST_FETCH} state_type;

   state_type       state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            pend_ff, pend_in;
   logic [FW-1:0]   rd_left_ff, rd_left_in;
   logic [FW-1:0]   deliv_ff, deliv_in;
   logic            out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      pend_in      = pend_ff;
      rd_left_in   = rd_left_ff;
      deliv_in     = deliv_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = out_free;
            cmd.accept = req_valid && out_free;
            if (cmd.accept) begin
               if (stat.fetch_run) begin
                  state_in   = ST_FETCH;
                  rd_left_in = stat.run_len[FW-1:0];
                  deliv_in   = stat.run_len[FW-1:0];
                  pend_in    = 1'b0;
               end else begin
                  cmd.load_step = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            cmd.load_byte = pend_ff && out_free;
            cmd.last      = deliv_ff == FW'(1);
            cmd.rd_issue  = (rd_left_ff != '0) && (!pend_ff || cmd.load_byte);
            if (cmd.rd_issue) begin
               rd_left_in = rd_left_ff - 1'b1;
               pend_in    = 1'b1;
            end else if (cmd.load_byte) begin
               pend_in = 1'b0;
            end
            if (cmd.load_byte) begin
               deliv_in = deliv_ff - 1'b1;
               if (cmd.last) state_in = ST_IDLE;
            end
         end
      endcase
      if (cmd.load_step || cmd.load_byte) rsp_valid_in = 1'b1;
      else if (rsp_ready)                  rsp_valid_in = 1'b0;
      else                                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rd_left_ff   <= '0;
         deliv_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         rd_left_ff   <= rd_left_in;
         deliv_ff     <= deliv_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/tsbb_checker.sv -----
// Port-level checker for the TCP send byte buffer, bound to the top level.
// Depends on tsbb_pkg and tcp_send_byte_buffer_top_assert.svh.
`timescale 1ns / 1ps
`include "tcp_send_byte_buffer_top_assert.svh"

module tsbb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input tsbb_pkg::rsp_payload_type rsp_payload
);
   import tsbb_pkg::*;

   // An empty response carries no byte and closes its run
   `TSBB_ASSERT_IMPL(a_empty_closes, clock, reset, rsp_valid && !rsp_payload.byte_valid, (rsp_payload.out_byte == '0) && rsp_payload.last_of_run)
   // Fetched bytes always report success
   `TSBB_ASSERT_IMPL(a_byte_ok, clock, reset, rsp_valid && rsp_payload.byte_valid, rsp_payload.status == STATUS_OK)
   // Within a run the head sequence does not move between bytes
   `TSBB_ASSERT_NEXT(a_run_steady, clock, reset, rsp_valid && rsp_ready && rsp_payload.byte_valid && !rsp_payload.last_of_run, !rsp_valid || (rsp_payload.head_seq_out == $past(rsp_payload.head_seq_out)))
   // A stalled response holds
   `TSBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind tcp_send_byte_buffer_top tsbb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

// ----- tb/sv/tsbb_ring_tracker.sv -----
// Predicts and checks the responses of the TCP send byte buffer.
// Depends on tsbb_pkg and on the request and response interfaces in tsbb_if.
`timescale 1ns / 1ps

module tsbb_ring_tracker (
   input  logic                             clock,
   input  logic                             reset,
   tsbb_req_if                              req_mon,
   tsbb_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [tsbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               awaited_count,
   output logic [tsbb_pkg::SEQ_W-1:0]       head_view,
   output logic [tsbb_pkg::CNT_W-1:0]       held_view,
   output logic [tsbb_pkg::CNT_W-1:0]       sent_view
);
   import tsbb_pkg::*;

   localparam int RING_SLOTS = RING_BYTES_DEFAULT;
   localparam int FETCH_CAP  = MAX_FETCH_DEFAULT;

   logic [BYTE_W-1:0] ring_store [0:RING_SLOTS-1];
   logic [SEQ_W-1:0]  head_seq;
   logic [15:0]       head_index;
   logic [CNT_W-1:0]  held_count;
   logic [CNT_W-1:0]  sent_count;
   logic [CNT_W-1:0]  max_buffer;

   rsp_payload_type awaited_rsp_q [$];

   function automatic rsp_payload_type shape_result(logic [BYTE_W-1:0] data, logic valid,
                                                    logic last, logic [STATUS_W-1:0] status);
      rsp_payload_type r;
      r.out_byte     = data;
      r.byte_valid   = valid;
      r.last_of_run  = last;
      r.status       = status;
      r.free_space   = (max_buffer > held_count) ? max_buffer - held_count : '0;
      r.head_seq_out = head_seq;
      r.unsent_count = (held_count >= sent_count) ? held_count - sent_count : '0;
      return r;
   endfunction

   function automatic bit field_ok(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Work out the responses of one accepted request and advance the ring state
   task automatic project_request(input req_payload_type rq);
      logic [31:0] offset;
      logic [31:0] want_len;
      logic [31:0] avail;
      logic [31:0] span;
      logic [31:0] drop;
      logic [15:0] pos;
      offset = rq.seq_number - head_seq;
      case (rq.req_type)
         REQ_APPEND: begin
            if (held_count < max_buffer && !held_count[16]) begin
               pos = head_index + held_count[15:0];
               ring_store[pos] = rq.data_byte;
               held_count++;
               awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_OK));
            end else begin
               awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_FULL));
            end
         end
         REQ_FETCH: begin
            want_len = (rq.fetch_length > FETCH_CAP) ? FETCH_CAP : rq.fetch_length;
            avail    = (offset <= held_count) ? held_count - offset : 0;
            span     = (want_len < avail) ? want_len : avail;
            if (offset[31]) begin
               awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_STALE));
            end else if (span == 0) begin
               awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_EMPTY));
            end else if (offset > sent_count) begin
               awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_GAP));
            end else begin
               // new bytes move the sent mark; re-read bytes leave it alone
               if (offset + span > sent_count) sent_count = CNT_W'(offset + span);
               for (int unsigned i = 0; i < span; i++) begin
                  pos = head_index + offset[15:0] + i[15:0];
                  awaited_rsp_q.push_back(shape_result(ring_store[pos], 1'b1,
                                                       i + 1 == span, STATUS_OK));
               end
            end
         end
         REQ_ACK: begin
            if (offset != 0 && !offset[31]) begin
               drop       = (offset < sent_count) ? offset : sent_count;
               held_count = held_count - drop[CNT_W-1:0];
               sent_count = sent_count - drop[CNT_W-1:0];
               head_seq   = head_seq + drop;
               head_index = head_index + drop[15:0];
               if (held_count == 0) head_seq = rq.seq_number;
            end
            awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_OK));
         end
         default: begin
            awaited_rsp_q.push_back(shape_result('0, 1'b0, 1'b1, STATUS_EMPTY));
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      bit              ok;
      if (reset) begin
         head_seq       = '0;
         head_index     = '0;
         held_count     = '0;
         sent_count     = '0;
         max_buffer     = MAX_BUFFER_RESET;
         mismatch_count = 0;
         awaited_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_BUFFER: max_buffer = csr_wdata[CNT_W-1:0];
               CSR_START_SEQ:  head_seq   = csr_wdata;
               default: ;
            endcase
         end
         // a response at this edge belongs to an earlier request: check it first
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (awaited_rsp_q.size() == 0) begin
               $error("response with no request outstanding: 0x%0h", got);
               mismatch_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               ok = field_ok("out_byte", 32'(want.out_byte), 32'(got.out_byte))
                  & field_ok("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid))
                  & field_ok("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run))
                  & field_ok("status", 32'(want.status), 32'(got.status))
                  & field_ok("free_space", 32'(want.free_space), 32'(got.free_space))
                  & field_ok("head_seq_out", want.head_seq_out, got.head_seq_out)
                  & field_ok("unsent_count", 32'(want.unsent_count),
                             32'(got.unsent_count));
               if (!ok) mismatch_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) project_request(req_mon.payload);
      end
      awaited_count = awaited_rsp_q.size();
      head_view     = head_seq;
      held_view     = held_count;
      sent_view     = sent_count;
   end

endmodule

// ----- tb/sv/tcp_send_byte_buffer_top_tb.sv -----
// Stimulus and verdict for the TCP send byte buffer.
// Depends on tsbb_pkg, tsbb_if, tsbb_ring_tracker and tcp_send_byte_buffer_top.
`timescale 1ns / 1ps

module tcp_send_byte_buffer_top_tb;
   import tsbb_pkg::*;

   // code left free by the request encoding; the block must answer it as empty
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     hold_off_left;
   int                     cycle_count;

   int                     mismatch_count;
   int                     awaited_count;
   logic [SEQ_W-1:0]       head_view;
   logic [CNT_W-1:0]       held_view;
   logic [CNT_W-1:0]       sent_view;

   tsbb_req_if req_ch ();
   tsbb_rsp_if rsp_ch ();

   tcp_send_byte_buffer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tsbb_ring_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .head_view      (head_view),
      .held_view      (held_view),
      .sent_view      (sent_view)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up on a hung run: the slowest correct one stays well below this
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[tcp_send_byte_buffer_top] ERROR");
            $finish;
         end
      end
   end

   // Response side: stall at random, or hold off completely while a long
   // stretch is pending so that the block backs up into its request port
   initial begin
      rsp_ch.ready = 1'b0;
      hold_off_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one request, idling first at random, and hold it until taken.
   // Entered and left at a falling edge; valid stays high on return.
   task automatic send_request(input req_payload_type rq);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= rq;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] data,
                              input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
      req_payload_type rq;
      rq.req_type     = kind;
      rq.data_byte    = data;
      rq.seq_number   = seq;
      rq.fetch_length = len;
      send_request(rq);
   endtask

   // Drop valid and wait until every predicted response has come back,
   // then let the block settle its last state update
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write both registers on consecutive edges; the block must be idle
   task automatic reconfigure(input logic [CNT_W-1:0] max_buf, input logic [SEQ_W-1:0] start);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_BUFFER;
      csr_wdata <= CSR_DATA_W'(max_buf);
      @(negedge clock);
      csr_index <= CSR_START_SEQ;
      csr_wdata <= start;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed traffic around the live window (appends, fetches at
   // or inside the sent mark, acks up to two past it), the rest noise: random,
   // stale, gapped and zero-length fetches, the unused code and wild acks
   function automatic req_payload_type random_request();
      req_payload_type rq;
      int pick;
      rq.req_type     = REQ_APPEND;
      rq.data_byte    = BYTE_W'($urandom_range(0, 255));
      rq.seq_number   = $urandom;
      rq.fetch_length = LEN_W'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         rq.req_type = REQ_APPEND;
      end else if (pick < 75) begin
         rq.req_type = REQ_FETCH;
         if ($urandom_range(0, 1) == 0) rq.seq_number = head_view + sent_view;
         else rq.seq_number = head_view + $urandom_range(0, sent_view);
         rq.fetch_length = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(1, 127))
                                                       : LEN_W'($urandom_range(1, 16));
      end else if (pick < 88) begin
         rq.req_type   = REQ_ACK;
         rq.seq_number = head_view + $urandom_range(1, sent_view + 2);
      end else begin
         case ($urandom_range(0, 5))
            0: rq.req_type = REQ_FETCH;
            1: begin
               rq.req_type   = REQ_FETCH;
               rq.seq_number = head_view - $urandom_range(1, 5000);
            end
            2: begin
               rq.req_type   = REQ_FETCH;
               rq.seq_number = head_view + sent_view + $urandom_range(1, 8);
            end
            3: begin
               rq.req_type     = REQ_FETCH;
               rq.seq_number   = head_view + $urandom_range(0, held_view);
               rq.fetch_length = '0;
            end
            4: rq.req_type = REQ_UNUSED;
            default: rq.req_type = REQ_ACK;
         endcase
      end
      return rq;
   endfunction

   task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                            input int hold_at);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         // hold the response side off for a long stretch, keep offering
         if (i == hold_at) hold_off_left = 250;
         send_request(random_request());
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_MAX_BUFFER;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty buffer first, then a short stream walked through
      // every fetch and acknowledge outcome
      send_fields(REQ_FETCH, 8'h00, head_view, 7'd5);
      send_fields(REQ_ACK, 8'h00, head_view, 7'd0);
      send_fields(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
      send_fields(REQ_APPEND, 8'h00, 32'h0, 7'd0);
      send_fields(REQ_APPEND, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
      send_fields(REQ_APPEND, 8'hA5, 32'hA5A5_A5A5, 7'h55);
      send_fields(REQ_APPEND, 8'h5A, 32'h5A5A_5A5A, 7'h2A);
      send_fields(REQ_FETCH, 8'h00, head_view, 7'd0);           // zero length
      send_fields(REQ_FETCH, 8'h00, head_view + 3, 7'd2);       // gap past sent mark
      send_fields(REQ_FETCH, 8'h00, head_view, 7'd2);           // first send
      send_fields(REQ_FETCH, 8'h00, head_view + 1, 7'd10);      // resend plus new
      send_fields(REQ_FETCH, 8'h00, head_view + 4, 7'd3);       // at the tail
      send_fields(REQ_FETCH, 8'h00, head_view - 1, 7'd3);       // stale
      send_fields(REQ_FETCH, 8'h00, head_view, 7'h7F);          // over the cap
      send_fields(REQ_ACK, 8'h00, head_view + 2, 7'd0);
      send_fields(REQ_ACK, 8'h00, head_view, 7'd0);             // at head: no change
      send_fields(REQ_ACK, 8'h00, head_view + 100, 7'd0);       // past sent, empties
      send_fields(REQ_ACK, 8'h00, head_view - 5, 7'd0);         // stale ack
      drain_responses();

      // Zero capacity: every append refused
      reconfigure('0, 32'hFFFF_FFFE);
      send_fields(REQ_APPEND, 8'h11, 32'h0, 7'd0);
      drain_responses();

      // Three bytes across the sequence wrap, the fourth refused
      reconfigure(17'd3, 32'hFFFF_FFFE);
      for (int i = 0; i < 4; i++) send_fields(REQ_APPEND, 8'(i + 8'h40), 32'h0, 7'd0);
      send_fields(REQ_FETCH, 8'h00, head_view, 7'd3);
      drain_responses();

      // Capacity below the held count: free space reads zero, appends refused
      reconfigure(17'd1, 32'h0000_0000);
      send_fields(REQ_APPEND, 8'h22, 32'h0, 7'd0);
      drain_responses();

      // Random phases: sender light and receiver heavy idling, the reverse,
      // then full rate with a long receiver hold-off
      reconfigure(17'd65536, 32'hFFFF_FFF0);
      run_phase(110, 12, 54, -1);
      drain_responses();

      reconfigure(17'd24, $urandom);
      run_phase(110, 54, 12, -1);
      drain_responses();

      reconfigure(MAX_BUFFER_RESET, 32'hFFFF_FFFF);
      run_phase(100, 0, 0, 20);
      drain_responses();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[tcp_send_byte_buffer_top] OK");
      end else begin
         $display("[tcp_send_byte_buffer_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/tsbb_pkg.sv
src/tsbb_if.sv
src/tsbb_datapath.sv
src/tsbb_controller.sv
src/tcp_send_byte_buffer_top.sv
src/tsbb_checker.sv
tb/sv/tsbb_ring_tracker.sv
tb/sv/tcp_send_byte_buffer_top_tb.sv
